@@ sv/framed_byte_ring_mailbox_unit_assert.svh @@
// Assertion macros for the mailbox unit.
// Both sample on the rising clock edge and stay quiet while rst_n is low.
`ifndef FRAMED_BYTE_RING_MAILBOX_UNIT_ASSERT_SVH
`define FRAMED_BYTE_RING_MAILBOX_UNIT_ASSERT_SVH

// Check the consequent in the same cycle as the antecedent.
`define FBRM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define FBRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/fbrm_pkg.sv @@
`timescale 1ns / 1ps
package fbrm_pkg;

  localparam int CAPACITY   = 1024;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CMD_W      = 3;
  localparam int DATA_W     = 8;
  localparam int LEN_W      = 10;
  localparam int ST_W       = 3;
  localparam int CNT_W      = 10;
  localparam int PREFIX_LEN = 4;
  // Low half of the prefix, and one spare bit for the compare against used.
  localparam int PLEN_W     = 16;
  localparam int CMP_W      = PLEN_W + 1;
  localparam int IDX_W      = $clog2(PREFIX_LEN);

  typedef enum logic [CMD_W-1:0] {
    CMD_WBEGIN = 3'd0,
    CMD_WBYTE  = 3'd1,
    CMD_RBEGIN = 3'd2,
    CMD_RBYTE  = 3'd3,
    CMD_PUSH   = 3'd4,
    CMD_POP    = 3'd5
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_NOSPACE = 3'd1,
    ST_NOMSG   = 3'd2,
    ST_SKIPPED = 3'd3,
    ST_SEQERR  = 3'd4,
    ST_EMPTY   = 3'd5
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic latch;  // capture the accepted item
    logic exec;   // decode and run single-step commands
    logic wpre;   // write one prefix byte
    logic rpre;   // fetch one prefix byte
    logic rchk;   // judge the fetched prefix
    logic rdat;   // finish a one-byte read
    logic push;   // move the result into the output register
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_wpre;
    logic need_rpre;
    logic need_rdat;
    logic idx_last;
    logic out_free;
  } dp_sts_t;

endpackage

@@ sv/fbrm_ram.sv @@
`timescale 1ns / 1ps
module fbrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/fbrm_ctrl.sv @@
`timescale 1ns / 1ps
module fbrm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fbrm_pkg::dp_sts_t  sts,
  output fbrm_pkg::ctl_cmd_t cmd
);
  import fbrm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EXEC = 7'b0000010,
    S_WPRE = 7'b0000100,
    S_RPRE = 7'b0001000,
    S_RCHK = 7'b0010000,
    S_RDAT = 7'b0100000,
    S_PUSH = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.need_wpre)      state_nxt = S_WPRE;
        else if (sts.need_rpre) state_nxt = S_RPRE;
        else if (sts.need_rdat) state_nxt = S_RDAT;
        else                    state_nxt = S_PUSH;
      end
      S_WPRE: begin
        if (sts.idx_last) state_nxt = S_PUSH;
      end
      S_RPRE: begin
        if (sts.idx_last) state_nxt = S_RCHK;
      end
      S_RCHK: state_nxt = S_PUSH;
      S_RDAT: state_nxt = S_PUSH;
      S_PUSH: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign cmd.latch = (state_r == S_IDLE) && in_valid;
  assign cmd.exec  = (state_r == S_EXEC);
  assign cmd.wpre  = (state_r == S_WPRE);
  assign cmd.rpre  = (state_r == S_RPRE);
  assign cmd.rchk  = (state_r == S_RCHK);
  assign cmd.rdat  = (state_r == S_RDAT);
  assign cmd.push  = (state_r == S_PUSH) && sts.out_free;

endmodule

@@ sv/fbrm_datapath.sv @@
`timescale 1ns / 1ps
module fbrm_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fbrm_pkg::ctl_cmd_t          cmd,
  output fbrm_pkg::dp_sts_t           sts,
  input  logic [fbrm_pkg::CMD_W-1:0]  in_cmd,
  input  logic [fbrm_pkg::DATA_W-1:0] in_data,
  input  logic [fbrm_pkg::LEN_W-1:0]  in_length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fbrm_pkg::ST_W-1:0]   out_status,
  output logic [fbrm_pkg::DATA_W-1:0] out_rdata,
  output logic [fbrm_pkg::LEN_W-1:0]  out_msg_len,
  output logic                        out_last,
  output logic [fbrm_pkg::CNT_W-1:0]  out_used,
  output logic [fbrm_pkg::CNT_W-1:0]  out_free
);
  import fbrm_pkg::*;

  // Latched item
  logic [CMD_W-1:0]  cmd_r;
  logic [DATA_W-1:0] data_r;
  logic [LEN_W-1:0]  len_r;

  // Ring state
  logic [ADDR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wc_r, wc_nxt, rc_r, rc_nxt;
  logic [LEN_W-1:0]  wrem_r, wrem_nxt, rrem_r, rrem_nxt;
  logic              wopen_r, wopen_nxt, ropen_r, ropen_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  // Prefix capture
  logic [DATA_W-1:0] pb0_r, pb0_nxt, pb1_r, pb1_nxt;
  logic              phi_nz_r, phi_nz_nxt;

  // Pending result
  logic [ST_W-1:0]   res_status_r, res_status_nxt;
  logic [DATA_W-1:0] res_rdata_r, res_rdata_nxt;
  logic [LEN_W-1:0]  res_mlen_r, res_mlen_nxt;
  logic              res_last_r, res_last_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]   out_status_r;
  logic [DATA_W-1:0] out_rdata_r;
  logic [LEN_W-1:0]  out_mlen_r;
  logic              out_last_r;
  logic [CNT_W-1:0]  out_used_r, out_free_r;

  // RAM port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_q;

  logic [ADDR_W-1:0] used_w, free_w, wp_plus4, rp_plus4;
  logic [PLEN_W-1:0] plen;
  logic              plen_hi_nz, fits, quick;

  fbrm_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  assign used_w   = wp_r - rp_r;
  assign free_w   = ADDR_W'(CAPACITY - 1) - used_w;
  assign wp_plus4 = wp_r + ADDR_W'(PREFIX_LEN);
  assign rp_plus4 = rp_r + ADDR_W'(PREFIX_LEN);
  assign fits     = (CMP_W'(len_r) + CMP_W'(PREFIX_LEN)) <= CMP_W'(free_w);
  assign plen       = {pb1_r, pb0_r};
  assign plen_hi_nz = phi_nz_r || (ram_q != '0);

  // Read the cursor for a read byte, otherwise the read pointer plus offset
  assign ram_raddr = (cmd_r == CMD_RBYTE) ? rc_r : rp_r + ADDR_W'(idx_r);

  assign sts.need_wpre = (cmd_r == CMD_WBEGIN) && !wopen_r && fits;
  assign sts.need_rpre = (cmd_r == CMD_RBEGIN) && !ropen_r &&
                         (used_w >= ADDR_W'(PREFIX_LEN));
  assign sts.need_rdat = ((cmd_r == CMD_RBYTE) && ropen_r) ||
                         ((cmd_r == CMD_POP) && !ropen_r && (used_w != '0));
  assign sts.idx_last  = (idx_r == IDX_W'(PREFIX_LEN - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign quick = cmd.exec && !sts.need_wpre && !sts.need_rpre && !sts.need_rdat;

  always_comb begin
    wp_nxt         = wp_r;
    rp_nxt         = rp_r;
    wc_nxt         = wc_r;
    rc_nxt         = rc_r;
    wrem_nxt       = wrem_r;
    rrem_nxt       = rrem_r;
    wopen_nxt      = wopen_r;
    ropen_nxt      = ropen_r;
    idx_nxt        = idx_r;
    pb0_nxt        = pb0_r;
    pb1_nxt        = pb1_r;
    phi_nz_nxt     = phi_nz_r;
    res_status_nxt = res_status_r;
    res_rdata_nxt  = res_rdata_r;
    res_mlen_nxt   = res_mlen_r;
    res_last_nxt   = res_last_r;
    ram_we         = 1'b0;
    ram_waddr      = wp_r;
    ram_wdata      = data_r;

    if (quick) begin
      res_status_nxt = ST_OK;
      res_rdata_nxt  = '0;
      res_mlen_nxt   = '0;
      res_last_nxt   = 1'b0;
      case (cmd_r)
        CMD_WBEGIN: res_status_nxt = wopen_r ? ST_SEQERR : ST_NOSPACE;
        CMD_WBYTE: begin
          if (!wopen_r) begin
            res_status_nxt = ST_SEQERR;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = wc_r;
            wc_nxt    = wc_r + 1'b1;
            wrem_nxt  = wrem_r - 1'b1;
            if (wrem_r == LEN_W'(1)) begin
              res_last_nxt = 1'b1;
              wp_nxt       = wc_r + 1'b1;
              wopen_nxt    = 1'b0;
            end
          end
        end
        CMD_RBEGIN: res_status_nxt = ropen_r ? ST_SEQERR : ST_NOMSG;
        CMD_RBYTE:  res_status_nxt = ST_SEQERR;
        CMD_PUSH: begin
          if (wopen_r) begin
            res_status_nxt = ST_SEQERR;
          end else if (free_w == '0) begin
            res_status_nxt = ST_NOSPACE;
          end else begin
            ram_we = 1'b1;
            wp_nxt = wp_r + 1'b1;
          end
        end
        CMD_POP:  res_status_nxt = ropen_r ? ST_SEQERR : ST_EMPTY;
        default:  res_status_nxt = ST_SEQERR;
      endcase
    end

    if (cmd.wpre) begin
      ram_we    = 1'b1;
      ram_waddr = wp_r + ADDR_W'(idx_r);
      case (idx_r)
        IDX_W'(0): ram_wdata = len_r[DATA_W-1:0];
        IDX_W'(1): ram_wdata = DATA_W'(len_r >> DATA_W);
        default:   ram_wdata = '0;
      endcase
      idx_nxt = idx_r + 1'b1;
      if (sts.idx_last) begin
        wc_nxt         = wp_plus4;
        wrem_nxt       = len_r;
        res_status_nxt = ST_OK;
        res_rdata_nxt  = '0;
        res_mlen_nxt   = '0;
        res_last_nxt   = 1'b0;
        if (len_r == '0) begin
          wp_nxt = wp_plus4;
        end else begin
          wopen_nxt = 1'b1;
        end
      end
    end

    // Read data arrives in the cycle after its address (registered RAM read)
    if (cmd.rpre) begin
      idx_nxt = idx_r + 1'b1;
      case (idx_r)
        IDX_W'(1): pb0_nxt    = ram_q;
        IDX_W'(2): pb1_nxt    = ram_q;
        IDX_W'(3): phi_nz_nxt = (ram_q != '0);
        default:   ;
      endcase
    end

    if (cmd.rchk) begin
      res_rdata_nxt = '0;
      res_last_nxt  = 1'b0;
      res_mlen_nxt  = plen[LEN_W-1:0];
      res_status_nxt = ST_OK;
      if (plen_hi_nz ||
          (CMP_W'(used_w) < (CMP_W'(plen) + CMP_W'(PREFIX_LEN)))) begin
        res_status_nxt = ST_NOMSG;
        res_mlen_nxt   = '0;
      end else if (plen > PLEN_W'(len_r)) begin
        res_status_nxt = ST_SKIPPED;
        rp_nxt         = rp_plus4 + plen[ADDR_W-1:0];
      end else if (plen == '0) begin
        rp_nxt = rp_plus4;
      end else begin
        rc_nxt    = rp_plus4;
        rrem_nxt  = plen[LEN_W-1:0];
        ropen_nxt = 1'b1;
      end
    end

    if (cmd.rdat) begin
      res_status_nxt = ST_OK;
      res_rdata_nxt  = ram_q;
      res_mlen_nxt   = '0;
      res_last_nxt   = 1'b0;
      if (cmd_r == CMD_RBYTE) begin
        rc_nxt   = rc_r + 1'b1;
        rrem_nxt = rrem_r - 1'b1;
        if (rrem_r == LEN_W'(1)) begin
          res_last_nxt = 1'b1;
          rp_nxt       = rc_r + 1'b1;
          ropen_nxt    = 1'b0;
        end
      end else begin
        rp_nxt = rp_r + 1'b1;
      end
    end
  end

  assign out_valid_nxt = cmd.push || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      wc_r        <= '0;
      rc_r        <= '0;
      wrem_r      <= '0;
      rrem_r      <= '0;
      wopen_r     <= 1'b0;
      ropen_r     <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      wc_r        <= wc_nxt;
      rc_r        <= rc_nxt;
      wrem_r      <= wrem_nxt;
      rrem_r      <= rrem_nxt;
      wopen_r     <= wopen_nxt;
      ropen_r     <= ropen_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r  <= in_cmd;
      data_r <= in_data;
      len_r  <= in_length;
    end
    pb0_r        <= pb0_nxt;
    pb1_r        <= pb1_nxt;
    phi_nz_r     <= phi_nz_nxt;
    res_status_r <= res_status_nxt;
    res_rdata_r  <= res_rdata_nxt;
    res_mlen_r   <= res_mlen_nxt;
    res_last_r   <= res_last_nxt;
    if (cmd.push) begin
      out_status_r <= res_status_r;
      out_rdata_r  <= res_rdata_r;
      out_mlen_r   <= res_mlen_r;
      out_last_r   <= res_last_r;
      out_used_r   <= CNT_W'(used_w);
      out_free_r   <= CNT_W'(free_w);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_rdata   = out_rdata_r;
  assign out_msg_len = out_mlen_r;
  assign out_last    = out_last_r;
  assign out_used    = out_used_r;
  assign out_free    = out_free_r;

endmodule

@@ sv/framed_byte_ring_mailbox_unit.sv @@
`timescale 1ns / 1ps
// Framed byte ring mailbox: a byte ring carrying length-prefixed messages.
// Input channel in_valid/in_stall carries one command (in_cmd, in_data,
// in_length); a transfer takes place on a rising edge with in_valid high and
// in_stall low. Each command yields exactly one result transfer on the
// out_valid/out_stall channel (out_status, out_rdata, out_msg_len, out_last,
// out_used, out_free).
// Steps per command, from input transfer to the next possible one:
//   decode and hand-over for write byte, raw push, and any command rejected at decode,
//   plus a registered RAM read for read byte and raw pop,
//   plus four prefix bytes, one RAM write each, for a write begin that fits,
//   plus four RAM reads and a check for a read begin that finds a prefix.
// The output register is loaded in the cycle before the next input transfer
// can occur; one command is in flight at a time, since in_stall stays high
// from acceptance until the result is handed over.
// A result waiting on a stalled receiver does not block acceptance: the next
// command runs up to its final step and holds there until the output
// register is taken. out_* payload holds while out_stall is high.
// Reset (rst_n low, synchronous) clears pointers, cursors, counts and open
// flags and empties the output register. Ring bytes are not cleared.
module framed_byte_ring_mailbox_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [fbrm_pkg::CMD_W-1:0]  in_cmd,
  input  logic [fbrm_pkg::DATA_W-1:0] in_data,
  input  logic [fbrm_pkg::LEN_W-1:0]  in_length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fbrm_pkg::ST_W-1:0]   out_status,
  output logic [fbrm_pkg::DATA_W-1:0] out_rdata,
  output logic [fbrm_pkg::LEN_W-1:0]  out_msg_len,
  output logic                        out_last,
  output logic [fbrm_pkg::CNT_W-1:0]  out_used,
  output logic [fbrm_pkg::CNT_W-1:0]  out_free
);
  import fbrm_pkg::*;

  `include "framed_byte_ring_mailbox_unit_assert.svh"

  ctl_cmd_t ctl_cmd;
  dp_sts_t  dp_sts;

  // Sequence each command: decode, prefix or read-data steps, then hand the result over
  fbrm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (dp_sts),
    .cmd     (ctl_cmd)
  );

  // Hold the pointers, the ring RAM and the output register
  fbrm_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (ctl_cmd),
    .sts        (dp_sts),
    .in_cmd     (in_cmd),
    .in_data    (in_data),
    .in_length  (in_length),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_rdata  (out_rdata),
    .out_msg_len(out_msg_len),
    .out_last   (out_last),
    .out_used   (out_used),
    .out_free   (out_free)
  );

  // One command in flight: a transfer closes the input until it completes
  `FBRM_ASSERT_NEXT(a_accept_closes, in_valid && !in_stall, in_stall, "input open after transfer")
  // A final payload byte is only flagged on success
  `FBRM_ASSERT_NOW(a_last_ok, out_valid && out_last, out_status == ST_OK, "last without ok")
  // Returned bytes only come with a successful read
  `FBRM_ASSERT_NOW(a_rdata_ok, out_valid && (out_rdata != '0), out_status == ST_OK, "rdata without ok")
  // A message length is reported only when a message was opened or skipped
  `FBRM_ASSERT_NOW(a_mlen_status, out_valid && (out_msg_len != '0), (out_status == ST_OK) || (out_status == ST_SKIPPED), "msg_len with bad status")

endmodule

@@ dv/mailbox_tracker_pkg.sv @@
`timescale 1ns / 1ps
package mailbox_tracker_pkg;
  import fbrm_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] rdata;
    logic [LEN_W-1:0]  msg_len;
    logic              last;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  spare;
  } mailbox_result_t;

  // Shadow copy of the ring and its pointers; predicts one result per command.
  class mailbox_tracker;
    bit [DATA_W-1:0] ring [CAPACITY];
    bit [ADDR_W-1:0] wr_ptr, rd_ptr, wr_cur, rd_cur;
    int unsigned     wr_left, rd_left;
    bit              wr_open, rd_open;
    mailbox_result_t due_results[$];
    int unsigned     mismatches;

    function int unsigned fill_level();
      bit [ADDR_W-1:0] span;
      span = wr_ptr - rd_ptr;
      return int'(span);
    endfunction

    function int unsigned room_left();
      return CAPACITY - fill_level() - 1;
    endfunction

    // Wrap an offset from a ring position.
    function bit [ADDR_W-1:0] ahead(bit [ADDR_W-1:0] pos, int unsigned step);
      return ADDR_W'(pos + step);
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] data,
                               logic [LEN_W-1:0] length);
      mailbox_result_t r;
      longint unsigned plen;
      r = '0;
      r.status = ST_OK;
      case (cmd)
        CMD_WBEGIN: begin
          if (wr_open) begin
            r.status = ST_SEQERR;
          end else if (PREFIX_LEN + length > room_left()) begin
            r.status = ST_NOSPACE;
          end else begin
            ring[wr_ptr]           = length[7:0];
            ring[ahead(wr_ptr, 1)] = DATA_W'(length >> 8);
            ring[ahead(wr_ptr, 2)] = '0;
            ring[ahead(wr_ptr, 3)] = '0;
            wr_cur  = ahead(wr_ptr, PREFIX_LEN);
            wr_left = length;
            if (length == 0) wr_ptr = wr_cur;
            else wr_open = 1'b1;
          end
        end
        CMD_WBYTE: begin
          if (!wr_open) begin
            r.status = ST_SEQERR;
          end else begin
            ring[wr_cur] = data;
            wr_cur = ahead(wr_cur, 1);
            wr_left--;
            if (wr_left == 0) begin
              r.last  = 1'b1;
              wr_ptr  = wr_cur;
              wr_open = 1'b0;
            end
          end
        end
        CMD_RBEGIN: begin
          if (rd_open) begin
            r.status = ST_SEQERR;
          end else if (fill_level() < PREFIX_LEN) begin
            r.status = ST_NOMSG;
          end else begin
            plen = {ring[ahead(rd_ptr, 3)], ring[ahead(rd_ptr, 2)],
                    ring[ahead(rd_ptr, 1)], ring[rd_ptr]};
            if (fill_level() < PREFIX_LEN + plen) begin
              r.status = ST_NOMSG;
            end else begin
              r.msg_len = plen[LEN_W-1:0];
              if (plen > length) begin
                r.status = ST_SKIPPED;
                rd_ptr = ahead(rd_ptr, PREFIX_LEN + int'(plen));
              end else if (plen == 0) begin
                rd_ptr = ahead(rd_ptr, PREFIX_LEN);
              end else begin
                rd_cur  = ahead(rd_ptr, PREFIX_LEN);
                rd_left = int'(plen);
                rd_open = 1'b1;
              end
            end
          end
        end
        CMD_RBYTE: begin
          if (!rd_open) begin
            r.status = ST_SEQERR;
          end else begin
            r.rdata = ring[rd_cur];
            rd_cur = ahead(rd_cur, 1);
            rd_left--;
            if (rd_left == 0) begin
              r.last  = 1'b1;
              rd_ptr  = rd_cur;
              rd_open = 1'b0;
            end
          end
        end
        CMD_PUSH: begin
          if (wr_open) r.status = ST_SEQERR;
          else if (room_left() < 1) r.status = ST_NOSPACE;
          else begin
            ring[wr_ptr] = data;
            wr_ptr = ahead(wr_ptr, 1);
          end
        end
        CMD_POP: begin
          if (rd_open) r.status = ST_SEQERR;
          else if (fill_level() == 0) r.status = ST_EMPTY;
          else begin
            r.rdata = ring[rd_ptr];
            rd_ptr = ahead(rd_ptr, 1);
          end
        end
        default: r.status = ST_SEQERR;
      endcase
      r.used  = CNT_W'(fill_level());
      r.spare = CNT_W'(room_left());
      due_results.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task compare_field(string name, logic [CNT_W-1:0] got,
                       logic [CNT_W-1:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    task check_result(mailbox_result_t got);
      mailbox_result_t want;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result with none outstanding, status %0h", got.status));
        return;
      end
      want = due_results.pop_front();
      compare_field("status",  CNT_W'(got.status), CNT_W'(want.status));
      compare_field("rdata",   CNT_W'(got.rdata),  CNT_W'(want.rdata));
      compare_field("msg_len", got.msg_len,        want.msg_len);
      compare_field("last",    CNT_W'(got.last),   CNT_W'(want.last));
      compare_field("used",    got.used,           want.used);
      compare_field("free",    got.spare,          want.spare);
    endtask
  endclass

endpackage

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Mailbox checks: every command transfer is mirrored into a shadow ring, whose
// prediction is compared field by field with the next result transfer.
module tb_top;
  import fbrm_pkg::*;
  import mailbox_tracker_pkg::*;

  // Random traffic budget; the one-off ring fill (about a thousand items)
  // comes on top of it.
  localparam int RANDOM_ITEMS  = 250;
  // Generous allowance for stalls on top of the longest command.
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 3'd7;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   in_cmd    = '0;
  logic [DATA_W-1:0]  in_data   = '0;
  logic [LEN_W-1:0]   in_length = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ST_W-1:0]    out_status;
  logic [DATA_W-1:0]  out_rdata;
  logic [LEN_W-1:0]   out_msg_len;
  logic               out_last;
  logic [CNT_W-1:0]   out_used;
  logic [CNT_W-1:0]   out_free;

  // Idle percentages for sender and receiver; start with a lazy receiver.
  int unsigned send_idle_pct = 6;
  int unsigned recv_idle_pct = 46;
  int unsigned sent_items;
  int unsigned quiet_cycles;

  mailbox_tracker tracker = new();

  framed_byte_ring_mailbox_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd      (in_cmd),
    .in_data     (in_data),
    .in_length   (in_length),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_rdata   (out_rdata),
    .out_msg_len (out_msg_len),
    .out_last    (out_last),
    .out_used    (out_used),
    .out_free    (out_free)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver back-pressure: one fresh draw per cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Check every result transfer and watch for a hung block.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        tracker.check_result({out_status, out_rdata, out_msg_len, out_last,
                              out_used, out_free});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("[%0t] no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Offer one command, idling first at random; hold the payload until the
  // transfer, then hand it to the shadow ring.
  task automatic offer_item(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] data,
                            logic [LEN_W-1:0] length);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_cmd    <= cmd;
    in_data   <= data;
    in_length <= length;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_command(cmd, data, length);
    sent_items++;
  endtask

  // Any command code, random fields; keep accepted write lengths short so
  // stray messages stay cheap to finish.
  task automatic send_noise();
    logic [CMD_W-1:0] cmd;
    logic [LEN_W-1:0] length;
    cmd    = CMD_W'($urandom_range(7));
    length = LEN_W'($urandom);
    if (cmd == CMD_WBEGIN && PREFIX_LEN + length <= tracker.room_left())
      length = LEN_W'(length[3:0]);
    offer_item(cmd, DATA_W'($urandom), length);
  endtask

  // Open a message and feed its payload; stray commands may cut in.
  task automatic write_message(int unsigned len, int unsigned noise_pct);
    offer_item(CMD_WBEGIN, DATA_W'($urandom), LEN_W'(len));
    while (tracker.wr_open) begin
      if ($urandom_range(99) < noise_pct) send_noise();
      else offer_item(CMD_WBYTE, DATA_W'($urandom), LEN_W'($urandom));
    end
  endtask

  // Ask for a message up to max_len bytes and drain it if it opens.
  task automatic read_message(int unsigned max_len, int unsigned noise_pct);
    offer_item(CMD_RBEGIN, DATA_W'($urandom), LEN_W'(max_len));
    while (tracker.rd_open) begin
      if ($urandom_range(99) < noise_pct) send_noise();
      else offer_item(CMD_RBYTE, DATA_W'($urandom), LEN_W'($urandom));
    end
  endtask

  initial begin
    int unsigned base, phase, pick, room, lower, held, len, mark, fill_items;
    bit filled;
    filled = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty ring, out-of-sequence commands, unknown code.
    offer_item(CMD_POP,     8'h00, 10'd0);
    offer_item(CMD_RBEGIN,  8'hFF, 10'd1023);
    offer_item(CMD_RBYTE,   8'h00, 10'd0);
    offer_item(CMD_WBYTE,   8'hFF, 10'd0);
    offer_item(CMD_UNKNOWN, 8'hFF, 10'h3FF);
    // Oversized write, then a zero-length message written and consumed.
    offer_item(CMD_WBEGIN,  8'h00, 10'd1023);
    offer_item(CMD_WBEGIN,  8'h00, 10'd0);
    offer_item(CMD_RBEGIN,  8'h00, 10'd0);
    // Two-byte message; nested begin and raw push are refused while it is open.
    offer_item(CMD_WBEGIN,  8'h00, 10'd2);
    offer_item(CMD_WBEGIN,  8'h00, 10'd1);
    offer_item(CMD_PUSH,    8'h11, 10'd0);
    offer_item(CMD_WBYTE,   8'h00, 10'd0);
    offer_item(CMD_WBYTE,   8'hFF, 10'd0);
    offer_item(CMD_WBEGIN,  8'h00, 10'd1);
    offer_item(CMD_WBYTE,   8'hA5, 10'd0);
    // Skip the first message as too long, open the second, poke it while open.
    offer_item(CMD_RBEGIN,  8'h00, 10'd1);
    offer_item(CMD_RBEGIN,  8'h00, 10'd1023);
    offer_item(CMD_RBEGIN,  8'h00, 10'd1023);
    offer_item(CMD_POP,     8'h00, 10'd0);
    offer_item(CMD_RBYTE,   8'h00, 10'd0);
    // Incomplete messages: too few bytes, then a prefix claiming unpublished payload.
    offer_item(CMD_PUSH,    8'h05, 10'd0);
    offer_item(CMD_RBEGIN,  8'h00, 10'd1023);
    repeat (3) offer_item(CMD_PUSH, 8'h00, 10'd0);
    offer_item(CMD_RBEGIN,  8'h00, 10'd1023);

    // Random: mostly well-formed messages with random content, some raw
    // traffic and noise. Split the run into three idling regimes; the ring
    // fill is left out of the split.
    base       = sent_items;
    fill_items = 0;
    while (sent_items - base - fill_items < RANDOM_ITEMS) begin
      phase = (sent_items - base - fill_items) * 3 / RANDOM_ITEMS;
      case (phase)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 46;
        end
        1: begin
          send_idle_pct = 46;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      if (phase == 1 && !filled) begin
        // Close anything open, drain to empty, then fill the ring to the brim
        // with one long message and push against the full ring.
        mark = sent_items;
        while (tracker.wr_open) offer_item(CMD_WBYTE, DATA_W'($urandom), '0);
        while (tracker.rd_open) offer_item(CMD_RBYTE, DATA_W'($urandom), '0);
        while (tracker.fill_level() != 0) begin
          held = tracker.fill_level();
          offer_item(CMD_RBEGIN, DATA_W'($urandom), '0);
          if (tracker.fill_level() == held)
            offer_item(CMD_POP, DATA_W'($urandom), LEN_W'($urandom));
        end
        write_message(tracker.room_left() - PREFIX_LEN, 0);
        offer_item(CMD_PUSH, DATA_W'($urandom), LEN_W'($urandom));
        offer_item(CMD_WBEGIN, DATA_W'($urandom), '0);
        // Drop the long message unread: one short of its length skips it.
        read_message(CAPACITY - PREFIX_LEN - 2, 0);
        fill_items = sent_items - mark;
        filled = 1'b1;
      end

      pick = $urandom_range(99);
      if (pick < 35) begin
        room  = tracker.room_left();
        lower = (room > 3) ? room - 3 : 0;
        case ($urandom_range(15))
          0: len = (room >= 4 && room <= 68) ? room - 4 : $urandom_range(12);
          1: len = $urandom_range(1023, lower);
          2: len = 0;
          default: len = $urandom_range(12);
        endcase
        write_message(len, 8);
      end else if (pick < 65) begin
        case ($urandom_range(9))
          0: len = 0;
          1: len = $urandom_range(1023);
          2: len = $urandom_range(8);
          default: len = 1023;
        endcase
        read_message(len, 8);
      end else if (pick < 78) begin
        repeat ($urandom_range(6, 1))
          offer_item(CMD_PUSH, DATA_W'($urandom), LEN_W'($urandom));
      end else if (pick < 88) begin
        repeat ($urandom_range(6, 1))
          offer_item(CMD_POP, DATA_W'($urandom), LEN_W'($urandom));
      end else begin
        repeat ($urandom_range(3, 1)) send_noise();
      end
    end

    // Stop offering, wait for the last results, then let the block settle.
    in_valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/fbrm_pkg.sv
sv/fbrm_ram.sv
sv/fbrm_ctrl.sv
sv/fbrm_datapath.sv
sv/framed_byte_ring_mailbox_unit.sv
dv/mailbox_tracker_pkg.sv
dv/tb_top.sv
